FILE: hdl/gtq_pkg.sv
// ----------------------------------------------------------------------------
// gtq_pkg
// Shared types and constants for the grouped team queue.
// ----------------------------------------------------------------------------
package gtq_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int NUM_GROUPS_DEF = 5;

    localparam int GROUP_W  = 3;
    localparam int ID_W     = 16;
    localparam int STATUS_W = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_ENQUEUED  = 2'd0,
        ST_DEQUEUED  = 2'd1,
        ST_DEQ_EMPTY = 2'd2,
        ST_ENQ_DROP  = 2'd3
    } t_status;

    typedef enum logic {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } t_opcode;

    // Contents of one node of the linked store, apart from its link.
    typedef struct packed {
        logic [GROUP_W-1:0] grp;
        logic [ID_W-1:0]    id;
    } t_node;

endpackage

FILE: hdl/gtq_ram.sv
// ----------------------------------------------------------------------------
// gtq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module gtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/grouped_team_queue.sv
// ----------------------------------------------------------------------------
// grouped_team_queue
// Team queue over a bounded linked store, with per-group insertion points.
// ----------------------------------------------------------------------------
// Usage. Commands arrive on the input channel (i_in_valid / o_in_ready) as
// one beat each: an enqueue carries a group and an id, a dequeue removes the
// head item. Every command gives exactly one result beat on the output
// channel (o_out_valid / i_out_ready) with a status, the dequeued item where
// there is one, and whether the queue is empty afterwards.
// A dropped enqueue or a dequeue on an empty queue is answered from the
// idle state; an enqueue that opens a new group run or joins a run at the
// tail finishes in S_ENQ, one spliced into the middle goes on through
// S_ENQ_LINK and S_ENQ_SPLICE, and a dequeue finishes in S_DEQ when it
// empties the queue and in S_DEQ_CHK otherwise. One command is in work at
// a time: the input is not ready again until the command has finished and
// its result has gone to the output register. The states follow the
// read-then-write sequence on the link memory, whose read data arrives in
// the cycle after the address.
// Reset leaves the queue empty. Slots are first handed out by a fill counter
// and later recycled through a free stack, so no clearing pass is needed and
// commands are accepted straight after reset.
// When the receiver stalls, the result waits in the output register; one
// further command is still accepted and worked on, and its result is held
// inside until the output register frees up.
// ----------------------------------------------------------------------------
module grouped_team_queue #(
    parameter int CAPACITY   = gtq_pkg::CAPACITY_DEF,
    parameter int NUM_GROUPS = gtq_pkg::NUM_GROUPS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_opcode,
    input  logic [gtq_pkg::GROUP_W-1:0] i_item_group,
    input  logic [gtq_pkg::ID_W-1:0]    i_item_id,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [gtq_pkg::STATUS_W-1:0] o_status,
    output logic [gtq_pkg::GROUP_W-1:0] o_out_group,
    output logic [gtq_pkg::ID_W-1:0]    o_out_id,
    output logic                        o_is_empty
);

    // Slot index, occupancy count and group index widths.
    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int NW = $bits(gtq_pkg::t_node);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENQ,
        S_ENQ_LINK,
        S_ENQ_SPLICE,
        S_DEQ,
        S_DEQ_CHK,
        S_HOLD
    } t_state;

    t_state r_state, n_state;

    // Queue control state.
    logic [SW-1:0]         r_head, n_head;
    logic [SW-1:0]         r_tail, n_tail;
    logic [CW-1:0]         r_used, n_used;
    logic [CW-1:0]         r_fresh, n_fresh;
    logic [CW-1:0]         r_stk, n_stk;
    logic [NUM_GROUPS-1:0] r_present, n_present;

    // Working registers of the command in progress.
    logic [gtq_pkg::GROUP_W-1:0] r_grp, n_grp;
    logic [gtq_pkg::ID_W-1:0]    r_id, n_id;
    logic [SW-1:0]               r_slot, n_slot;
    logic [SW-1:0]               r_last, n_last;

    // Result waiting for the output register.
    gtq_pkg::t_status            r_res_status, n_res_status;
    logic [gtq_pkg::GROUP_W-1:0] r_res_grp, n_res_grp;
    logic [gtq_pkg::ID_W-1:0]    r_res_id, n_res_id;
    logic                        r_res_empty, n_res_empty;

    // Output register.
    logic                        r_o_valid, n_o_valid;
    gtq_pkg::t_status            r_o_status, n_o_status;
    logic [gtq_pkg::GROUP_W-1:0] r_o_grp, n_o_grp;
    logic [gtq_pkg::ID_W-1:0]    r_o_id, n_o_id;
    logic                        r_o_empty, n_o_empty;

    // Memory ports.
    logic          next_we;
    logic [SW-1:0] next_waddr, next_wdata, next_raddr, next_q;
    logic          node_we;
    logic [SW-1:0] node_waddr, node_raddr;
    gtq_pkg::t_node node_wdata, node_q;
    logic          glast_we;
    logic [GW-1:0] glast_waddr, glast_raddr;
    logic [SW-1:0] glast_wdata, glast_q;
    logic          free_we;
    logic [SW-1:0] free_waddr, free_raddr, free_wdata, free_q;

    // Finishing a command.
    logic                        fin;
    gtq_pkg::t_status            fin_status;
    logic [gtq_pkg::GROUP_W-1:0] fin_grp;
    logic [gtq_pkg::ID_W-1:0]    fin_id;
    logic                        fin_empty;

    logic          out_free;
    logic          in_accept;
    logic          grp_ok;
    logic          full;
    logic [SW-1:0] new_slot;
    logic [GW-1:0] grp_idx;
    logic [GW-1:0] deq_idx;

    // Links between nodes.
    gtq_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_next_ram (
        .i_clk  (i_clk),
        .i_we   (next_we),
        .i_waddr(next_waddr),
        .i_wdata(next_wdata),
        .i_raddr(next_raddr),
        .o_rdata(next_q)
    );

    // Group and id of each node.
    gtq_ram #(.WIDTH(NW), .DEPTH(CAPACITY)) u_node_ram (
        .i_clk  (i_clk),
        .i_we   (node_we),
        .i_waddr(node_waddr),
        .i_wdata(node_wdata),
        .i_raddr(node_raddr),
        .o_rdata(node_q)
    );

    // Last waiting slot of each group.
    gtq_ram #(.WIDTH(SW), .DEPTH(NUM_GROUPS)) u_glast_ram (
        .i_clk  (i_clk),
        .i_we   (glast_we),
        .i_waddr(glast_waddr),
        .i_wdata(glast_wdata),
        .i_raddr(glast_raddr),
        .o_rdata(glast_q)
    );

    // Stack of recycled slots.
    gtq_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_free_ram (
        .i_clk  (i_clk),
        .i_we   (free_we),
        .i_waddr(free_waddr),
        .i_wdata(free_wdata),
        .i_raddr(free_raddr),
        .o_rdata(free_q)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign out_free   = !r_o_valid || i_out_ready;
    assign grp_ok     = (32'(i_item_group) < 32'(NUM_GROUPS));
    assign full       = (r_used == CW'(CAPACITY));
    assign new_slot   = (r_stk != '0) ? free_q : r_fresh[SW-1:0];
    assign grp_idx    = GW'(r_grp);
    assign deq_idx    = GW'(r_res_grp);

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_used       = r_used;
        n_fresh      = r_fresh;
        n_stk        = r_stk;
        n_present    = r_present;
        n_grp        = r_grp;
        n_id         = r_id;
        n_slot       = r_slot;
        n_last       = r_last;
        n_res_status = r_res_status;
        n_res_grp    = r_res_grp;
        n_res_id     = r_res_id;
        n_res_empty  = r_res_empty;
        n_o_valid    = r_o_valid && !i_out_ready;
        n_o_status   = r_o_status;
        n_o_grp      = r_o_grp;
        n_o_id       = r_o_id;
        n_o_empty    = r_o_empty;

        next_we     = 1'b0;
        next_waddr  = r_last;
        next_wdata  = r_slot;
        next_raddr  = r_head;
        node_we     = 1'b0;
        node_waddr  = new_slot;
        node_wdata  = '{grp: r_grp, id: r_id};
        node_raddr  = r_head;
        glast_we    = 1'b0;
        glast_waddr = grp_idx;
        glast_wdata = new_slot;
        glast_raddr = GW'(i_item_group);
        free_we     = 1'b0;
        free_waddr  = r_stk[SW-1:0];
        free_wdata  = r_head;
        free_raddr  = SW'(r_stk - CW'(1));

        fin        = 1'b0;
        fin_status = gtq_pkg::ST_ENQUEUED;
        fin_grp    = '0;
        fin_id     = '0;
        fin_empty  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                // Reads for both commands are issued here; the data arrives
                // in the next state.
                if (in_accept) begin
                    n_grp = i_item_group;
                    n_id  = i_item_id;
                    if (i_opcode == gtq_pkg::OP_ENQUEUE) begin
                        if (full || !grp_ok) begin
                            fin        = 1'b1;
                            fin_status = gtq_pkg::ST_ENQ_DROP;
                            fin_empty  = (r_used == '0);
                        end else begin
                            n_state = S_ENQ;
                        end
                    end else begin
                        if (r_used == '0) begin
                            fin        = 1'b1;
                            fin_status = gtq_pkg::ST_DEQ_EMPTY;
                            fin_empty  = 1'b1;
                        end else begin
                            n_state = S_DEQ;
                        end
                    end
                end
            end

            S_ENQ: begin
                // Allocate a slot and store the item.
                n_slot = new_slot;
                n_last = glast_q;
                n_used = r_used + CW'(1);
                if (r_stk != '0) begin
                    n_stk = r_stk - CW'(1);
                end else begin
                    n_fresh = r_fresh + CW'(1);
                end
                node_we             = 1'b1;
                glast_we            = 1'b1;
                n_present[grp_idx]  = 1'b1;
                if (!r_present[grp_idx]) begin
                    // New group run at the tail.
                    if (r_used == '0) begin
                        n_head = new_slot;
                    end else begin
                        next_we    = 1'b1;
                        next_waddr = r_tail;
                        next_wdata = new_slot;
                    end
                    n_tail = new_slot;
                    fin    = 1'b1;
                end else if (glast_q == r_tail) begin
                    // The group's run ends at the tail: simply append.
                    next_we    = 1'b1;
                    next_waddr = glast_q;
                    next_wdata = new_slot;
                    n_tail     = new_slot;
                    fin        = 1'b1;
                end else begin
                    // Splice into the middle: fetch the link that follows.
                    next_raddr = glast_q;
                    n_state    = S_ENQ_LINK;
                end
            end

            S_ENQ_LINK: begin
                next_we    = 1'b1;
                next_waddr = r_slot;
                next_wdata = next_q;
                n_state    = S_ENQ_SPLICE;
            end

            S_ENQ_SPLICE: begin
                next_we    = 1'b1;
                next_waddr = r_last;
                next_wdata = r_slot;
                fin        = 1'b1;
            end

            S_DEQ: begin
                // Head node and its link have arrived; recycle the slot.
                n_res_grp = node_q.grp;
                n_res_id  = node_q.id;
                n_used    = r_used - CW'(1);
                free_we   = 1'b1;
                n_stk     = r_stk + CW'(1);
                if (r_used == CW'(1)) begin
                    n_present[GW'(node_q.grp)] = 1'b0;
                    fin        = 1'b1;
                    fin_status = gtq_pkg::ST_DEQUEUED;
                    fin_grp    = node_q.grp;
                    fin_id     = node_q.id;
                    fin_empty  = 1'b1;
                end else begin
                    n_head     = next_q;
                    node_raddr = next_q;
                    n_state    = S_DEQ_CHK;
                end
            end

            S_DEQ_CHK: begin
                // The group's run ends when the new head is of another group.
                if (node_q.grp != r_res_grp) begin
                    n_present[deq_idx] = 1'b0;
                end
                fin        = 1'b1;
                fin_status = gtq_pkg::ST_DEQUEUED;
                fin_grp    = r_res_grp;
                fin_id     = r_res_id;
            end

            S_HOLD: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_res_status;
                    n_o_grp    = r_res_grp;
                    n_o_id     = r_res_id;
                    n_o_empty  = r_res_empty;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            if (out_free) begin
                n_o_valid  = 1'b1;
                n_o_status = fin_status;
                n_o_grp    = fin_grp;
                n_o_id     = fin_id;
                n_o_empty  = fin_empty;
                n_state    = S_IDLE;
            end else begin
                n_res_status = fin_status;
                n_res_grp    = fin_grp;
                n_res_id     = fin_id;
                n_res_empty  = fin_empty;
                n_state      = S_HOLD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_tail    <= '0;
            r_used    <= '0;
            r_fresh   <= '0;
            r_stk     <= '0;
            r_present <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_used    <= n_used;
            r_fresh   <= n_fresh;
            r_stk     <= n_stk;
            r_present <= n_present;
            r_o_valid <= n_o_valid;
        end
        r_grp        <= n_grp;
        r_id         <= n_id;
        r_slot       <= n_slot;
        r_last       <= n_last;
        r_res_status <= n_res_status;
        r_res_grp    <= n_res_grp;
        r_res_id     <= n_res_id;
        r_res_empty  <= n_res_empty;
        r_o_status   <= n_o_status;
        r_o_grp      <= n_o_grp;
        r_o_id       <= n_o_id;
        r_o_empty    <= n_o_empty;
    end

    assign o_out_valid = r_o_valid;
    assign o_status    = r_o_status;
    assign o_out_group = r_o_grp;
    assign o_out_id    = r_o_id;
    assign o_is_empty  = r_o_empty;

`ifndef SYNTHESIS
    // Every slot handed out by the fill counter is either live or stacked.
    a_slot_accounting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used + r_stk) == r_fresh)
        else $error("slot accounting broken");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(CAPACITY))
        else $error("occupancy beyond capacity");

    // An idle, empty queue has no group run open.
    a_empty_no_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_used == '0) |-> (r_present == '0))
        else $error("group left open in empty queue");

    // A dequeue on an empty queue answers in the next cycle if nothing waits.
    a_empty_deq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_opcode == gtq_pkg::OP_DEQUEUE && r_used == '0 && out_free)
        |=> (o_out_valid && o_status == gtq_pkg::ST_DEQ_EMPTY && o_is_empty))
        else $error("empty dequeue not answered");
`endif

endmodule
